// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication on the same edge
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared constants for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int FIELD_W = 10;
    localparam int ARENA_WORDS_DEF = 1022;
    localparam logic [FIELD_W-1:0] THR_RESET = 10'd10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

// File: rtl/core/boundary_tag_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_allocator
// First-fit boundary-tag heap manager over a single-port word arena.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, request_size and
//   block_address. One transaction is taken at a time; in_stall stays high
//   until the result has been placed in the output register.
//   Output channel (out_valid / out_stall) returns ok, granted_address and
//   granted_size, one result per input transaction. A held result does not
//   block the next input; the block waits only when a second result is
//   ready while the first is still stalled.
//   cfg channel writes split_threshold; write it only while idle.
// Sequence (one memory access per cycle, registered read):
//   alloc: a walk along the free list, then the writes of a grant; the list
//   relinking is skipped when the last free block is handed out whole.
//   free:  the tag reads, then the reads and writes of the merge case.
//   Long free-list walks dominate the time of an alloc.
// Reset: a clearing pass writes all ARENA_WORDS+2 words (1024 by default)
//   and lays down the initial free block; in_stall is high during it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boundary_tag_allocator
    import bta_pkg::*;
#(
    parameter int ARENA_WORDS = ARENA_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [FIELD_W-1:0] request_size,
    input  logic [FIELD_W-1:0] block_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [FIELD_W-1:0] granted_address,
    output logic [FIELD_W-1:0] granted_size,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data
);

    localparam int D  = ARENA_WORDS + 2;
    localparam int AW = $clog2(D);
    localparam int CW = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int HW = $clog2(D + 1);
    localparam logic [AW+1:0] D_X = (AW+2)'(D);

    typedef logic [AW-1:0] addr_t;
    typedef struct packed {
        logic  tag;
        addr_t size;
        addr_t left;
        addr_t right;
    } word_t;

    localparam addr_t A_LAST  = addr_t'(D - 1);
    localparam addr_t A_ARENA = addr_t'(ARENA_WORDS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SRCH  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [2:0] OP_WHOLE = 3'd0;
    localparam logic [2:0] OP_SPLIT = 3'd1;
    localparam logic [2:0] OP_FPRE  = 3'd2;
    localparam logic [2:0] OP_FE    = 3'd3;
    localparam logic [2:0] OP_F11   = 3'd4;
    localparam logic [2:0] OP_F01   = 3'd5;
    localparam logic [2:0] OP_F10   = 3'd6;
    localparam logic [2:0] OP_F00   = 3'd7;

    function automatic addr_t wrap_link(addr_t x);
        logic [AW+1:0] v;
        v = {2'b00, x};
        if (v >= D_X) v = v - D_X;
        return v[AW-1:0];
    endfunction

    // (a + b - minus1) modulo the store depth
    function automatic addr_t wrap_sum(addr_t a, addr_t b, logic minus1);
        logic [AW+1:0] v;
        v = {2'b00, a} + {2'b00, b} + (minus1 ? D_X - 1'b1 : '0);
        for (int i = 0; i < 3; i++) begin
            if (v >= D_X) v = v - D_X;
        end
        return v[AW-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(addr_t x);
        logic [CW-1:0] e;
        e = CW'(x);
        return e[FIELD_W-1:0];
    endfunction

    function automatic word_t init_word(addr_t a);
        word_t w;
        w = '0;
        if (a == '0) w.tag = 1'b1;
        if (a == addr_t'(1)) begin
            w.size  = A_ARENA;
            w.left  = addr_t'(1);
            w.right = addr_t'(1);
        end
        if (a == A_ARENA) w.left = addr_t'(1);
        if (a == A_ARENA + addr_t'(1)) w.tag = 1'b1;
        return w;
    endfunction

    word_t mem [D];
    word_t rdata_reg;
    logic  we;
    addr_t wa, ra;
    word_t wd;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [3:0]         step_reg, step_next;
    addr_t              clr_reg, clr_next;
    addr_t              p_reg, p_next, f_reg, f_next, t_reg, t_next, s_reg, s_next;
    addr_t              lft_reg, lft_next, rgt_reg, rgt_next;
    addr_t              sz_reg, sz_next, sp_reg, sp_next, st_reg, st_next;
    addr_t              ma_reg, ma_next, head_reg, head_next;
    logic               l_reg, l_next;
    logic [FIELD_W-1:0] n_reg, n_next, thr_reg, thr_next;
    logic [HW-1:0]      hops_reg, hops_next;
    logic               res_ok_reg, res_ok_next;
    addr_t              res_addr_reg, res_addr_next, res_size_reg, res_size_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic [FIELD_W-1:0] gaddr_reg, gaddr_next, gsize_reg, gsize_next;
    addr_t              step_addr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    // address of the current micro-step
    always_comb
    begin
        step_addr = p_reg;
        unique case (op_reg)
            OP_WHOLE:
                unique case (step_reg)
                    4'd0:    step_addr = head_reg;
                    4'd1:    step_addr = lft_reg;
                    4'd2:    step_addr = p_reg;
                    default: step_addr = f_reg;
                endcase
            OP_SPLIT:
                unique case (step_reg)
                    4'd0:    step_addr = f_reg;
                    4'd1:    step_addr = p_reg;
                    4'd2:    step_addr = wrap_sum(p_reg, sz_reg, 1'b1);
                    default: step_addr = wrap_sum(f_reg, addr_t'(1), 1'b0);
                endcase
            OP_FPRE:
                unique case (step_reg)
                    4'd0:    step_addr = p_reg;
                    4'd1:    step_addr = p_reg - addr_t'(1);
                    default: step_addr = wrap_sum(p_reg, sp_reg, 1'b0);
                endcase
            OP_FE:
                step_addr = (step_reg == 4'd0) ? p_reg : wrap_sum(p_reg, sp_reg, 1'b1);
            OP_F11:
                unique case (step_reg)
                    4'd0:    step_addr = p_reg;
                    4'd1:    step_addr = wrap_sum(p_reg, sp_reg, 1'b1);
                    4'd2:    step_addr = head_reg;
                    4'd3:    step_addr = lft_reg;
                    4'd4:    step_addr = p_reg;
                    default: step_addr = head_reg;
                endcase
            OP_F01:
                unique case (step_reg)
                    4'd0:    step_addr = s_reg;
                    4'd1:    step_addr = p_reg;
                    default: step_addr = wrap_sum(p_reg, sz_reg, 1'b1);
                endcase
            OP_F10:
                unique case (step_reg)
                    4'd0, 4'd2, 4'd5, 4'd8: step_addr = p_reg;
                    4'd1, 4'd4, 4'd7, 4'd9: step_addr = t_reg;
                    4'd3:                   step_addr = lft_reg;
                    4'd6:                   step_addr = rgt_reg;
                    default:                step_addr = wrap_sum(t_reg, sz_reg, 1'b1);
                endcase
            default:
                unique case (step_reg)
                    4'd0, 4'd5, 4'd7: step_addr = t_reg;
                    4'd1:             step_addr = lft_reg;
                    4'd2:             step_addr = rgt_reg;
                    4'd3:             step_addr = p_reg - addr_t'(1);
                    4'd4:             step_addr = p_reg;
                    4'd6:             step_addr = s_reg;
                    default:          step_addr = wrap_sum(t_reg, sz_reg, 1'b1);
                endcase
        endcase
    end

    always_comb
    begin
        word_t         rw;
        addr_t         nxt;
        logic          sz_ge;
        logic          last;
        logic [CW-1:0] left_over;

        rw             = rdata_reg;
        nxt            = wrap_link(rw.right);
        sz_ge          = CW'(rw.size) >= CW'(n_reg);
        left_over      = CW'(rw.size) - CW'(n_reg);
        last           = 1'b0;

        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        p_next         = p_reg;
        f_next         = f_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        lft_next       = lft_reg;
        rgt_next       = rgt_reg;
        sz_next        = sz_reg;
        sp_next        = sp_reg;
        st_next        = st_reg;
        ma_next        = ma_reg;
        head_next      = head_reg;
        l_next         = l_reg;
        n_next         = n_reg;
        thr_next       = thr_reg;
        hops_next      = hops_reg;
        res_ok_next    = res_ok_reg;
        res_addr_next  = res_addr_reg;
        res_size_next  = res_size_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        gaddr_next     = gaddr_reg;
        gsize_next     = gsize_reg;
        we             = 1'b0;
        wa             = ma_reg;
        wd             = rw;
        ra             = ma_reg;

        if (out_valid_reg && !out_stall) out_valid_next = 1'b0;
        if (cfg_valid) thr_next = cfg_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = init_word(clr_reg);
                clr_next = clr_reg + addr_t'(1);
                if (clr_reg == A_LAST) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    res_size_next = '0;
                    if (cmd == CMD_ALLOC)
                    begin
                        n_next = request_size;
                        if (request_size == '0 || head_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            p_next     = head_reg;
                            ra         = head_reg;
                            hops_next  = '0;
                            state_next = ST_SRCH;
                        end
                    end
                    else if (block_address == '0 ||
                             CW'(block_address) > CW'(ARENA_WORDS))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        p_next      = addr_t'(block_address);
                        res_ok_next = 1'b1;
                        op_next     = OP_FPRE;
                        step_next   = '0;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_SRCH:
            begin
                if (p_reg != '0 && !sz_ge && nxt != head_reg && hops_reg < HW'(D))
                begin
                    p_next    = nxt;
                    ra        = nxt;
                    hops_next = hops_reg + 1'b1;
                end
                else if (p_reg == '0 || !sz_ge)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sp_next    = rw.size;
                    lft_next   = wrap_link(rw.left);
                    f_next     = wrap_sum(p_reg, rw.size, 1'b1);
                    head_next  = nxt;
                    state_next = ST_RD;
                    step_next  = '0;
                    res_ok_next = 1'b1;
                    if (left_over <= CW'(thr_reg))
                    begin
                        op_next       = OP_WHOLE;
                        res_addr_next = p_reg;
                        res_size_next = rw.size;
                        if (nxt == p_reg)
                        begin
                            head_next = '0;
                            step_next = 4'd2;
                        end
                    end
                    else
                    begin
                        op_next       = OP_SPLIT;
                        res_size_next = addr_t'(n_reg);
                    end
                end
            end
            ST_RD:
            begin
                ma_next    = step_addr;
                ra         = step_addr;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                unique case (op_reg)
                    OP_WHOLE:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0:    wd.left  = lft_reg;
                            4'd1:    wd.right = head_reg;
                            4'd2:    wd.tag   = 1'b1;
                            default:
                            begin
                                wd.tag = 1'b1;
                                last   = 1'b1;
                            end
                        endcase
                    end
                    OP_SPLIT:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0: wd.tag = 1'b1;
                            4'd1:
                            begin
                                wd.size = rw.size - addr_t'(n_reg);
                                sz_next = rw.size - addr_t'(n_reg);
                            end
                            4'd2:
                            begin
                                wd.tag  = 1'b0;
                                wd.left = p_reg;
                                f_next  = ma_reg;
                            end
                            default:
                            begin
                                wd.tag        = 1'b1;
                                wd.size       = addr_t'(n_reg);
                                res_addr_next = ma_reg;
                                last          = 1'b1;
                            end
                        endcase
                    end
                    OP_FPRE:
                    begin
                        unique case (step_reg)
                            4'd0: sp_next = rw.size;
                            4'd1:
                            begin
                                l_next = rw.tag;
                                s_next = wrap_link(rw.left);
                            end
                            default:
                            begin
                                t_next    = ma_reg;
                                step_next = '0;
                                state_next = ST_RD;
                                priority if (head_reg == '0) op_next = OP_FE;
                                else if (l_reg && rw.tag) op_next = OP_F11;
                                else if (!l_reg && rw.tag) op_next = OP_F01;
                                else if (l_reg) op_next = OP_F10;
                                else op_next = OP_F00;
                            end
                        endcase
                    end
                    OP_FE:
                    begin
                        we      = 1'b1;
                        wd.tag  = 1'b0;
                        wd.left = p_reg;
                        if (step_reg == 4'd0)
                        begin
                            wd.right = p_reg;
                        end
                        else
                        begin
                            head_next = p_reg;
                            last      = 1'b1;
                        end
                    end
                    OP_F11:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0: wd.tag = 1'b0;
                            4'd1:
                            begin
                                wd.tag  = 1'b0;
                                wd.left = p_reg;
                            end
                            4'd2:
                            begin
                                we       = 1'b0;
                                lft_next = wrap_link(rw.left);
                            end
                            4'd3: wd.right = p_reg;
                            4'd4:
                            begin
                                wd.left  = lft_reg;
                                wd.right = head_reg;
                            end
                            default:
                            begin
                                wd.left   = p_reg;
                                head_next = p_reg;
                                last      = 1'b1;
                            end
                        endcase
                    end
                    OP_F01:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0: wd.size = rw.size + sp_reg;
                            4'd1:
                            begin
                                we      = 1'b0;
                                sz_next = rw.size;
                            end
                            default:
                            begin
                                wd.tag  = 1'b0;
                                wd.left = s_reg;
                                last    = 1'b1;
                            end
                        endcase
                    end
                    OP_F10:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0: wd.tag = 1'b0;
                            4'd1:
                            begin
                                we       = 1'b0;
                                lft_next = wrap_link(rw.left);
                            end
                            4'd2: wd.left  = lft_reg;
                            4'd3: wd.right = p_reg;
                            4'd4:
                            begin
                                we       = 1'b0;
                                rgt_next = wrap_link(rw.right);
                            end
                            4'd5: wd.right = rgt_reg;
                            4'd6: wd.left  = p_reg;
                            4'd7:
                            begin
                                we      = 1'b0;
                                st_next = rw.size;
                            end
                            4'd8: wd.size = rw.size + st_reg;
                            4'd9:
                            begin
                                we      = 1'b0;
                                sz_next = rw.size;
                            end
                            default:
                            begin
                                wd.left = p_reg;
                                if (head_reg == t_reg) head_next = p_reg;
                                last = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        we = 1'b1;
                        unique case (step_reg)
                            4'd0:
                            begin
                                we       = 1'b0;
                                lft_next = wrap_link(rw.left);
                                rgt_next = wrap_link(rw.right);
                            end
                            4'd1: wd.right = rgt_reg;
                            4'd2: wd.left  = lft_reg;
                            4'd3:
                            begin
                                we     = 1'b0;
                                s_next = wrap_link(rw.left);
                            end
                            4'd4:
                            begin
                                we      = 1'b0;
                                sp_next = rw.size;
                            end
                            4'd5:
                            begin
                                we      = 1'b0;
                                st_next = rw.size;
                            end
                            4'd6: wd.size = rw.size + sp_reg + st_reg;
                            4'd7:
                            begin
                                we      = 1'b0;
                                sz_next = rw.size;
                            end
                            default:
                            begin
                                wd.left = s_reg;
                                if (head_reg == t_reg) head_next = s_reg;
                                last = 1'b1;
                            end
                        endcase
                    end
                endcase
                // the tag-read pass hands over to the merge case on its last step
                if (op_reg != OP_FPRE || step_reg != 4'd2)
                begin
                    if (last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    gaddr_next     = to_field(res_addr_reg);
                    gsize_next     = to_field(res_size_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            head_reg      <= addr_t'(1);
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_FPRE;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        f_reg        <= f_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        lft_reg      <= lft_next;
        rgt_reg      <= rgt_next;
        sz_reg       <= sz_next;
        sp_reg       <= sp_next;
        st_reg       <= st_next;
        ma_reg       <= ma_next;
        l_reg        <= l_next;
        n_reg        <= n_next;
        hops_reg     <= hops_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        res_size_reg <= res_size_next;
        ok_reg       <= ok_next;
        gaddr_reg    <= gaddr_next;
        gsize_reg    <= gsize_next;
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign granted_address = gaddr_reg;
    assign granted_size    = gsize_reg;

    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != ST_IDLE)
    `ASSERT_NEXT(a_result_loaded, state_reg == ST_DONE && (!out_valid_reg || !out_stall), out_valid_reg)
    `ASSERT_IMPL(a_write_phase, we, state_reg == ST_CLEAR || state_reg == ST_WR)

endmodule
